// ----- src/oss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_pkg
// Shared types and codes for the ordered small set store and its cells.
// ----------------------------------------------------------------------------
package oss_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned ELEM_W        = 16;
  localparam int unsigned SIZE_W        = 4;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned KIND_W        = 2;

  typedef logic [ELEM_W-1:0]   elem_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [SIZE_W-1:0]   size_t;

  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_INSERT = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;
  localparam kind_t KIND_LIST   = 2'd3;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_OVERFLOW = 2'd1;
  localparam status_t STATUS_ZERO     = 2'd2;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic  clear;
    logic  locate;
    logic  drop;
    logic  append;
    logic  rotate;
    elem_t key;
    elem_t fill;
  } oss_cmd_t;

endpackage

// ----- src/oss_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oss_cell
// One slot of the set: holds an element and an occupied flag, compares it
// with the broadcast key and takes its right neighbor's element on a shift.
// ----------------------------------------------------------------------------
module oss_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  oss_pkg::oss_cmd_t cmd_i,
  input  logic             left_occ_i,
  input  logic             prefix_i,
  input  logic             right_occ_i,
  input  oss_pkg::elem_t   right_val_i,
  output logic             occ_o,
  output oss_pkg::elem_t   val_o,
  output logic             prefix_o
);
  import oss_pkg::*;

  logic  occ_q, occ_d;
  elem_t val_q, val_d;
  logic  match, shift, first_empty;

  assign match       = occ_q && (val_q == cmd_i.key);
  assign prefix_o    = prefix_i | match;
  assign shift       = occ_q && (cmd_i.rotate || (cmd_i.locate && prefix_o));
  assign first_empty = !occ_q && left_occ_i;

  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (cmd_i.clear) begin
      occ_d = 1'b0;
    end else if (shift) begin
      if (right_occ_i) begin
        val_d = right_val_i;
      end else if (cmd_i.drop) begin
        occ_d = 1'b0;
      end else begin
        val_d = cmd_i.fill;
      end
    end else if (cmd_i.append && first_empty) begin
      val_d = cmd_i.fill;
      occ_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign occ_o = occ_q;
  assign val_o = val_q;

endmodule

// ----- src/ordered_small_set_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_small_set_store
// Ordered set of up to SLOTS-1 distinct nonzero elements in a chain of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (kind, element) and results leave on the
// out channel (status, item_value, set_size, last), both valid/ready.
// Clear, insert and delete give one result, registered in the cycle after the
// transaction. Insert and delete compare the key in every cell at once and
// shift the matching cell and the cells behind it by one place in that same
// cycle, so one of these requests can be taken every cycle while the receiver
// keeps up. List takes the request, then emits one element per cycle while
// the receiver keeps up, by rotating the chain towards cell 0, which drives
// the output; the block stays busy until every element has been emitted, with
// last set on the final element (an empty set gives a single zero result).
// No request is taken during a list. When the receiver stalls, the result
// register holds and no new transaction is taken until it is freed.
// Reset empties the set; element storage itself is not cleared.
// ----------------------------------------------------------------------------
module ordered_small_set_store #(
  parameter int unsigned SLOTS = oss_pkg::SLOTS_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  oss_pkg::kind_t   kind_i,
  input  oss_pkg::elem_t   element_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output oss_pkg::status_t status_o,
  output oss_pkg::elem_t   item_value_o,
  output oss_pkg::size_t   set_size_o,
  output logic             last_o
);
  import oss_pkg::*;

  localparam int unsigned CAP = SLOTS - 1;
  localparam int unsigned CW  = $clog2(SLOTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rem_q, rem_d;
  logic    out_vld_q, out_vld_d;
  status_t out_status_q, out_status_d;
  elem_t   out_item_q, out_item_d;
  size_t   out_size_q, out_size_d;
  logic    out_last_q, out_last_d;

  oss_cmd_t cmd;
  logic [CAP:0] occ_w;
  elem_t        val_w [CAP+1];
  logic [CAP:0] pre_w;
  logic         in_acc, out_free, present, full, elem_nz;

  assign occ_w[CAP] = 1'b0;
  assign val_w[CAP] = '0;
  assign pre_w[0]   = 1'b0;

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic left_occ;
    if (i == 0) begin : g_head
      assign left_occ = 1'b1;
    end else begin : g_body
      assign left_occ = occ_w[i-1];
    end
    oss_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_occ_i  (left_occ),
      .prefix_i    (pre_w[i]),
      .right_occ_i (occ_w[i+1]),
      .right_val_i (val_w[i+1]),
      .occ_o       (occ_w[i]),
      .val_o       (val_w[i]),
      .prefix_o    (pre_w[i+1])
    );
  end

  assign present    = pre_w[CAP];
  assign full       = occ_w[CAP-1];
  assign elem_nz    = (element_i != '0);
  assign out_free   = !out_vld_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cmd          = '0;
    cmd.key      = element_i;
    cmd.fill     = element_i;
    state_d      = state_q;
    count_d      = count_q;
    rem_d        = rem_q;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_size_d   = out_size_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          out_vld_d    = 1'b1;
          out_status_d = STATUS_OK;
          out_item_d   = '0;
          out_last_d   = 1'b1;
          unique case (kind_i)
            KIND_CLEAR: begin
              cmd.clear = 1'b1;
              count_d   = '0;
            end
            KIND_INSERT: begin
              if (!elem_nz) begin
                out_status_d = STATUS_ZERO;
              end else if (!present && full) begin
                out_status_d = STATUS_OVERFLOW;
              end else begin
                cmd.locate = 1'b1;
                cmd.append = !present;
                if (!present) begin
                  count_d = count_q + CW'(1);
                end
              end
            end
            KIND_DELETE: begin
              if (!elem_nz) begin
                out_status_d = STATUS_ZERO;
              end else begin
                cmd.locate = 1'b1;
                cmd.drop   = 1'b1;
                if (present) begin
                  count_d = count_q - CW'(1);
                end
              end
            end
            KIND_LIST: begin
              if (count_q != '0) begin
                out_vld_d = 1'b0;
                rem_d     = count_q;
                state_d   = ST_LIST;
              end
            end
            default: begin
              out_status_d = STATUS_OK;
            end
          endcase
          out_size_d = SIZE_W'(count_d);
        end
      end
      ST_LIST: begin
        if (out_free) begin
          cmd.rotate   = 1'b1;
          cmd.fill     = val_w[0];
          out_vld_d    = 1'b1;
          out_status_d = STATUS_OK;
          out_item_d   = val_w[0];
          out_size_d   = SIZE_W'(count_q);
          out_last_d   = (rem_q == CW'(1));
          rem_d        = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_item_q   <= out_item_d;
    out_size_q   <= out_size_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_vld_q;
  assign status_o     = out_status_q;
  assign item_value_o = out_item_q;
  assign set_size_o   = out_size_q;
  assign last_o       = out_last_q;

  a_count_matches_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_w) == int'(count_q))
    else $error("held count differs from occupied cells");

  a_no_take_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST |-> !in_ready_o)
    else $error("request taken while listing");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == KIND_CLEAR |=> count_q == '0 && occ_w == '0)
    else $error("clear left elements behind");

  a_overflow_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && kind_i == KIND_INSERT && elem_nz && !present && full
      |=> out_status_q == STATUS_OVERFLOW && $stable(count_q))
    else $error("overflow not reported or set changed");

  a_list_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LIST && out_free && rem_q == CW'(1) |=> state_q == ST_IDLE && out_last_q)
    else $error("list did not end on last element");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered small set store.
// ----------------------------------------------------------------------------
// A queue of requests (directed corner cases, then random requests drawn
// mostly from a small pool of values so that inserts and deletes hit present
// elements and the set fills up) feeds a clocked driver. Every accepted
// transaction is applied to a shadow copy of the set, which yields the
// results the block must return. A clocked monitor compares each returned
// transaction field by field with the oldest one due. Both sides idle at
// random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import oss_pkg::*;

  localparam int unsigned SET_CAP      = SLOTS_DEFAULT - 1;
  localparam int unsigned POOL_SIZE    = 19;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTS   = 100;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef struct {
    kind_t kind;
    elem_t element;
  } set_request_t;

  typedef struct {
    status_t status;
    elem_t   item_value;
    size_t   set_size;
    logic    last;
  } set_result_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  kind_t   kind = KIND_CLEAR;
  elem_t   element = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  status_t status;
  elem_t   item_value;
  size_t   set_size;
  logic    last;

  set_request_t request_q[$];
  set_result_t  due_results_q[$];
  elem_t        shadow_set_q[$];
  elem_t        value_pool[POOL_SIZE];

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 64;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned hold_request = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  ordered_small_set_store #(
    .SLOTS(SLOTS_DEFAULT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .kind_i      (kind),
    .element_i   (element),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .item_value_o(item_value),
    .set_size_o  (set_size),
    .last_o      (last)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  task automatic report_mismatch(string msg);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endtask

  function automatic void queue_result(status_t st, elem_t value, logic is_last);
    set_result_t r;
    r.status     = st;
    r.item_value = value;
    r.set_size   = size_t'(shadow_set_q.size());
    r.last       = is_last;
    due_results_q.push_back(r);
  endfunction

  function automatic void apply_request_to_set(kind_t req_kind, elem_t req_elem);
    elem_t kept_q[$];
    if (req_kind == KIND_CLEAR) begin
      shadow_set_q.delete();
      queue_result(STATUS_OK, '0, 1'b1);
    end else if (req_kind == KIND_LIST) begin
      if (shadow_set_q.size() == 0) begin
        queue_result(STATUS_OK, '0, 1'b1);
      end else begin
        foreach (shadow_set_q[i]) begin
          queue_result(STATUS_OK, shadow_set_q[i], i == shadow_set_q.size() - 1);
        end
      end
    end else if (req_elem == '0) begin
      queue_result(STATUS_ZERO, '0, 1'b1);
    end else begin
      foreach (shadow_set_q[i]) begin
        if (shadow_set_q[i] != req_elem) begin
          kept_q.push_back(shadow_set_q[i]);
        end
      end
      if (req_kind == KIND_INSERT && kept_q.size() >= SET_CAP) begin
        queue_result(STATUS_OVERFLOW, '0, 1'b1);
      end else begin
        if (req_kind == KIND_INSERT) begin
          kept_q.push_back(req_elem);
        end
        shadow_set_q = kept_q;
        queue_result(STATUS_OK, '0, 1'b1);
      end
    end
  endfunction

  function automatic void push_request(kind_t k, elem_t e);
    set_request_t r;
    r.kind    = k;
    r.element = e;
    request_q.push_back(r);
  endfunction

  function automatic void push_random_requests(int unsigned count);
    int unsigned roll;
    kind_t       k;
    elem_t       e;
    for (int unsigned n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 45) begin
        k = KIND_INSERT;
      end else if (roll < 72) begin
        k = KIND_DELETE;
      end else if (roll < 93) begin
        k = KIND_LIST;
      end else begin
        k = KIND_CLEAR;
      end
      roll = $urandom_range(99);
      if (roll < 80) begin
        e = value_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (roll < 85) begin
        e = '0;
      end else begin
        e = elem_t'($urandom);
      end
      push_request(k, e);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic         taken;
    set_request_t req;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        apply_request_to_set(kind, element);
        accepted_count++;
      end
      if (in_valid && !taken) begin
        in_valid <= 1'b1;
      end else if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = request_q.pop_front();
        in_valid <= 1'b1;
        kind     <= req.kind;
        element  <= req.element;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    set_result_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0h size %0d",
                                    item_value, set_size));
        end else begin
          want = due_results_q.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
          end
          if (item_value !== want.item_value) begin
            report_mismatch($sformatf("item_value got %0h expected %0h",
                                      item_value, want.item_value));
          end
          if (set_size !== want.set_size) begin
            report_mismatch($sformatf("set_size got %0d expected %0d",
                                      set_size, want.set_size));
          end
          if (last !== want.last) begin
            report_mismatch($sformatf("last got %0b expected %0b", last, want.last));
          end
        end
      end
      if (hold_request != holds_served) begin
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_CYCLES;
        out_ready    <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_requests_sent();
    while (request_q.size() != 0 || in_valid) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned mark;
    foreach (value_pool[i]) begin
      value_pool[i] = elem_t'($urandom_range(1, 65535));
    end

    // empty set corners
    push_request(KIND_LIST, 16'hABCD);
    push_request(KIND_DELETE, 16'h0005);
    push_request(KIND_INSERT, 16'h0000);
    push_request(KIND_DELETE, 16'h0000);
    push_request(KIND_CLEAR, 16'hFFFF);
    // fill to capacity
    push_request(KIND_INSERT, 16'hFFFF);
    push_request(KIND_INSERT, 16'h0001);
    push_request(KIND_INSERT, 16'h8000);
    for (int unsigned i = 0; i < SET_CAP - 3; i++) begin
      push_request(KIND_INSERT, elem_t'(16'h0100 + i));
    end
    push_request(KIND_INSERT, 16'h1234);
    push_request(KIND_INSERT, 16'h0001);
    push_request(KIND_DELETE, 16'h8000);
    push_request(KIND_LIST, 16'h0000);
    push_random_requests(70);
    wait_requests_sent();

    send_idle_pct = 64;
    recv_idle_pct = 34;
    push_random_requests(70);
    wait_requests_sent();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    mark = accepted_count;
    push_random_requests(60);
    while (accepted_count < mark + 15 && request_q.size() != 0) begin
      @(negedge clk_i);
    end
    hold_request = hold_request + 1;
    wait_requests_sent();

    while (due_results_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (error_count == 0 && due_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
